// File: sv/lidar_sector_obstacle_scan_macros.svh
// Assertion macros for the lidar sector obstacle scan block.
`ifndef LIDAR_SECTOR_OBSTACLE_SCAN_MACROS_SVH
`define LIDAR_SECTOR_OBSTACLE_SCAN_MACROS_SVH
`ifndef SYNTHESIS
`define LSOS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define LSOS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LSOS_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define LSOS_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

// File: sv/lsos_pkg.sv
// Shared types and constants for the lidar sector obstacle scan block.
`timescale 1ns / 1ps
package lsos_pkg;

    localparam int MAX_SCAN_SAMPLES = 1024;
    localparam int IDX_W   = $clog2(MAX_SCAN_SAMPLES);
    localparam int LEN_W   = 11;
    localparam int N_W     = (IDX_W + 1 > LEN_W) ? IDX_W + 1 : LEN_W;
    localparam int B_W     = N_W + 3;
    localparam int RANGE_W = 16;
    localparam int SIDE_W  = 17;
    localparam int TOTAL_W = RANGE_W + IDX_W;
    localparam int CNT_W   = IDX_W + 1;
    localparam int PROD_W  = TOTAL_W + CNT_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [N_W-1:0]     MIN_SCAN        = N_W'(16);
    localparam logic [N_W-1:0]     MAX_SCAN        = N_W'(MAX_SCAN_SAMPLES);
    localparam logic [RANGE_W-1:0] NO_RETURN_MM    = 16'hFFFF;
    localparam logic [RANGE_W-1:0] FRONT_REAR_INIT = RANGE_W'(12000);
    localparam logic [SIDE_W-1:0]  SIDE_MIN_INIT   = SIDE_W'(100000);

    localparam logic [LEN_W-1:0]   SCAN_LENGTH_RST     = LEN_W'(360);
    localparam logic [RANGE_W-1:0] VALID_RANGE_MAX_RST = RANGE_W'(12000);
    localparam logic [RANGE_W-1:0] FRONT_LIMIT_RST     = RANGE_W'(1700);
    localparam logic [RANGE_W-1:0] REAR_LIMIT_RST      = RANGE_W'(700);
    localparam logic [RANGE_W-1:0] AVOID_LIMIT_RST     = RANGE_W'(1500);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCAN_LENGTH     = 3'd0,
        CFG_VALID_RANGE_MAX = 3'd1,
        CFG_FRONT_LIMIT     = 3'd2,
        CFG_REAR_LIMIT      = 3'd3,
        CFG_AVOID_LIMIT     = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [LEN_W-1:0]   scan_length;
        logic [RANGE_W-1:0] valid_range_max;
        logic [RANGE_W-1:0] front_limit;
        logic [RANGE_W-1:0] rear_limit;
        logic [RANGE_W-1:0] avoid_limit;
    } cfg_t;

    typedef struct packed {
        logic [RANGE_W-1:0] range;
        logic               hit;
        logic               valid;
        logic               in_front;
        logic               in_rear;
        logic               in_right;
        logic               in_left;
        logic               last;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    typedef struct packed {
        logic snap_full;
        logic snap_load;
        logic snap_move;
    } back_stat_t;

endpackage

// File: sv/lsos_front.sv
// Front end: sample counter and sector classification of each accepted item.
`timescale 1ns / 1ps
module lsos_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [lsos_pkg::RANGE_W-1:0]  range_mm,
    input  lsos_pkg::cfg_t                cfg,
    input  lsos_pkg::queue_stat_t         q_stat,
    output logic                          push,
    output lsos_pkg::item_t               item
);

    logic [lsos_pkg::IDX_W-1:0] idx_reg;
    logic [lsos_pkg::IDX_W-1:0] idx_next;
    logic [lsos_pkg::N_W-1:0]   len_raw;
    logic [lsos_pkg::N_W-1:0]   n;
    logic [lsos_pkg::B_W-1:0]   nx;
    logic [lsos_pkg::B_W-1:0]   i;
    logic [lsos_pkg::B_W-1:0]   b2;
    logic [lsos_pkg::B_W-1:0]   b3;
    logic [lsos_pkg::B_W-1:0]   b4;
    logic [lsos_pkg::B_W-1:0]   b5;
    logic [lsos_pkg::B_W-1:0]   b6;
    logic [lsos_pkg::B_W-1:0]   rear_mid;
    logic [lsos_pkg::B_W-1:0]   delta;
    logic                       last;
    logic                       hit;

    assign len_raw = lsos_pkg::N_W'(cfg.scan_length);

    always_comb
    begin
        priority if (len_raw < lsos_pkg::MIN_SCAN)
        begin
            n = lsos_pkg::MIN_SCAN;
        end
        else if (len_raw > lsos_pkg::MAX_SCAN)
        begin
            n = lsos_pkg::MAX_SCAN;
        end
        else
        begin
            n = len_raw;
        end
    end

    assign nx       = lsos_pkg::B_W'(n);
    assign i        = lsos_pkg::B_W'(idx_reg);
    assign b2       = (nx << 1) >> 4;
    assign b3       = ((nx << 1) + nx) >> 4;
    assign b4       = nx >> 2;
    assign b5       = ((nx << 2) + nx) >> 4;
    assign b6       = ((nx << 2) + (nx << 1)) >> 4;
    assign rear_mid = ((nx << 1) + nx) >> 2;
    assign delta    = nx >> 3;
    assign last     = (i + lsos_pkg::B_W'(1)) >= nx;
    assign hit      = range_mm != lsos_pkg::NO_RETURN_MM;

    assign in_ready = !q_stat.full;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        item.range    = range_mm;
        item.hit      = hit;
        item.valid    = hit && (range_mm != '0) && (range_mm < cfg.valid_range_max);
        item.in_front = (i >= b3) && (i < b5);
        item.in_rear  = (i <= rear_mid + delta) && (i >= rear_mid - delta);
        item.in_right = (i >= b2) && (i < b4);
        item.in_left  = (i >= b4) && (i < b6);
        item.last     = last;
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (push)
        begin
            idx_next = last ? '0 : idx_reg + lsos_pkg::IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

// File: sv/lsos_queue.sv
// Short item queue between the front and back parts.
`timescale 1ns / 1ps
module lsos_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  lsos_pkg::item_t        item_in,
    input  logic                   pop,
    output lsos_pkg::item_t        item_out,
    output lsos_pkg::queue_stat_t  stat
);

    lsos_pkg::item_t               mem_reg [lsos_pkg::QUEUE_DEPTH];
    logic [lsos_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [lsos_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [lsos_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [lsos_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [lsos_pkg::QPTR_W:0]     count_reg;
    logic [lsos_pkg::QPTR_W:0]     count_next;

    assign stat.full  = count_reg == (lsos_pkg::QPTR_W+1)'(lsos_pkg::QUEUE_DEPTH);
    assign stat.empty = count_reg == '0;
    assign item_out   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + lsos_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + lsos_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + (lsos_pkg::QPTR_W+1)'(1);
            2'b01:   count_next = count_reg - (lsos_pkg::QPTR_W+1)'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: sv/lsos_back.sv
// Back end: running sector minima and side sums, end-of-scan decision pipeline.
`timescale 1ns / 1ps
module lsos_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lsos_pkg::queue_stat_t         q_stat,
    input  lsos_pkg::item_t               head,
    output logic                          pop,
    input  lsos_pkg::cfg_t                cfg,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          front_obstacle,
    output logic                          rear_obstacle,
    output logic                          avoid_obstacle,
    output logic                          left_side_flag,
    output logic                          right_side_flag,
    output logic [lsos_pkg::SIDE_W-1:0]   right_min_mm,
    output logic [lsos_pkg::SIDE_W-1:0]   left_min_mm,
    output lsos_pkg::back_stat_t          stat
);

    logic [lsos_pkg::RANGE_W-1:0] fmin_reg, fmin_next;
    logic [lsos_pkg::RANGE_W-1:0] bmin_reg, bmin_next;
    logic [lsos_pkg::SIDE_W-1:0]  rmin_reg, rmin_next;
    logic [lsos_pkg::SIDE_W-1:0]  lmin_reg, lmin_next;
    logic [lsos_pkg::TOTAL_W-1:0] rtot_reg, rtot_next;
    logic [lsos_pkg::TOTAL_W-1:0] ltot_reg, ltot_next;
    logic [lsos_pkg::CNT_W-1:0]   rcnt_reg, rcnt_next;
    logic [lsos_pkg::CNT_W-1:0]   lcnt_reg, lcnt_next;

    logic [lsos_pkg::RANGE_W-1:0] u_fmin, u_bmin;
    logic [lsos_pkg::SIDE_W-1:0]  u_rmin, u_lmin;
    logic [lsos_pkg::TOTAL_W-1:0] u_rtot, u_ltot;
    logic [lsos_pkg::CNT_W-1:0]   u_rcnt, u_lcnt;
    logic [lsos_pkg::SIDE_W-1:0]  r_side;

    logic                         snap_valid_reg, snap_valid_next;
    logic [lsos_pkg::RANGE_W-1:0] snap_fmin_reg, snap_bmin_reg;
    logic [lsos_pkg::SIDE_W-1:0]  snap_rmin_reg, snap_lmin_reg;
    logic [lsos_pkg::TOTAL_W-1:0] snap_rtot_reg, snap_ltot_reg;
    logic [lsos_pkg::CNT_W-1:0]   snap_rcnt_reg, snap_lcnt_reg;

    logic                         prod_valid_reg, prod_valid_next;
    logic [lsos_pkg::PROD_W-1:0]  lhs_reg, rhs_reg;
    logic                         zero_reg, pf_reg, pb_reg, pa_reg;
    logic [lsos_pkg::SIDE_W-1:0]  p_rmin_reg, p_lmin_reg;

    logic                         out_valid_reg, out_valid_next;
    logic                         o_front_reg, o_rear_reg, o_avoid_reg, o_left_reg;
    logic [lsos_pkg::SIDE_W-1:0]  o_rmin_reg, o_lmin_reg;

    logic out_move, prod_move, prod_free, snap_move, snap_free, snap_load;

    assign out_move  = !out_valid_reg || out_ready;
    assign prod_move = prod_valid_reg && out_move;
    assign prod_free = !prod_valid_reg || out_move;
    assign snap_move = snap_valid_reg && prod_free;
    assign snap_free = !snap_valid_reg || prod_free;
    assign pop       = !q_stat.empty && (!head.last || snap_free);
    assign snap_load = pop && head.last;

    assign stat.snap_full = snap_valid_reg;
    assign stat.snap_load = snap_load;
    assign stat.snap_move = snap_move;

    assign r_side = lsos_pkg::SIDE_W'(head.range);

    always_comb
    begin
        u_fmin = (head.in_front && head.hit && head.range < fmin_reg) ? head.range : fmin_reg;
        u_bmin = (head.in_rear && head.hit && head.range < bmin_reg) ? head.range : bmin_reg;
        u_rmin = (head.in_right && head.hit && r_side < rmin_reg) ? r_side : rmin_reg;
        u_lmin = (head.in_left && head.hit && r_side < lmin_reg) ? r_side : lmin_reg;
        u_rtot = rtot_reg;
        u_rcnt = rcnt_reg;
        u_ltot = ltot_reg;
        u_lcnt = lcnt_reg;
        if (head.in_right && head.valid)
        begin
            u_rtot = rtot_reg + lsos_pkg::TOTAL_W'(head.range);
            u_rcnt = rcnt_reg + lsos_pkg::CNT_W'(1);
        end
        if (head.in_left && head.valid)
        begin
            u_ltot = ltot_reg + lsos_pkg::TOTAL_W'(head.range);
            u_lcnt = lcnt_reg + lsos_pkg::CNT_W'(1);
        end
    end

    always_comb
    begin
        fmin_next = fmin_reg;
        bmin_next = bmin_reg;
        rmin_next = rmin_reg;
        lmin_next = lmin_reg;
        rtot_next = rtot_reg;
        ltot_next = ltot_reg;
        rcnt_next = rcnt_reg;
        lcnt_next = lcnt_reg;
        if (pop)
        begin
            if (head.last)
            begin
                fmin_next = lsos_pkg::FRONT_REAR_INIT;
                bmin_next = lsos_pkg::FRONT_REAR_INIT;
                rmin_next = lsos_pkg::SIDE_MIN_INIT;
                lmin_next = lsos_pkg::SIDE_MIN_INIT;
                rtot_next = '0;
                ltot_next = '0;
                rcnt_next = '0;
                lcnt_next = '0;
            end
            else
            begin
                fmin_next = u_fmin;
                bmin_next = u_bmin;
                rmin_next = u_rmin;
                lmin_next = u_lmin;
                rtot_next = u_rtot;
                ltot_next = u_ltot;
                rcnt_next = u_rcnt;
                lcnt_next = u_lcnt;
            end
        end
    end

    always_comb
    begin
        snap_valid_next = snap_valid_reg;
        if (snap_load)
        begin
            snap_valid_next = 1'b1;
        end
        else if (snap_move)
        begin
            snap_valid_next = 1'b0;
        end
        prod_valid_next = prod_valid_reg;
        if (snap_move)
        begin
            prod_valid_next = 1'b1;
        end
        else if (prod_move)
        begin
            prod_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (prod_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmin_reg       <= lsos_pkg::FRONT_REAR_INIT;
            bmin_reg       <= lsos_pkg::FRONT_REAR_INIT;
            rmin_reg       <= lsos_pkg::SIDE_MIN_INIT;
            lmin_reg       <= lsos_pkg::SIDE_MIN_INIT;
            rtot_reg       <= '0;
            ltot_reg       <= '0;
            rcnt_reg       <= '0;
            lcnt_reg       <= '0;
            snap_valid_reg <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            fmin_reg       <= fmin_next;
            bmin_reg       <= bmin_next;
            rmin_reg       <= rmin_next;
            lmin_reg       <= lmin_next;
            rtot_reg       <= rtot_next;
            ltot_reg       <= ltot_next;
            rcnt_reg       <= rcnt_next;
            lcnt_reg       <= lcnt_next;
            snap_valid_reg <= snap_valid_next;
            prod_valid_reg <= prod_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_load)
        begin
            snap_fmin_reg <= u_fmin;
            snap_bmin_reg <= u_bmin;
            snap_rmin_reg <= u_rmin;
            snap_lmin_reg <= u_lmin;
            snap_rtot_reg <= u_rtot;
            snap_ltot_reg <= u_ltot;
            snap_rcnt_reg <= u_rcnt;
            snap_lcnt_reg <= u_lcnt;
        end
        if (snap_move)
        begin
            lhs_reg    <= lsos_pkg::PROD_W'(snap_ltot_reg) * lsos_pkg::PROD_W'(snap_rcnt_reg);
            rhs_reg    <= lsos_pkg::PROD_W'(snap_rtot_reg) * lsos_pkg::PROD_W'(snap_lcnt_reg);
            zero_reg   <= (snap_lcnt_reg == '0) || (snap_rcnt_reg == '0);
            pf_reg     <= snap_fmin_reg < cfg.front_limit;
            pb_reg     <= snap_bmin_reg < cfg.rear_limit;
            pa_reg     <= snap_fmin_reg < cfg.avoid_limit;
            p_rmin_reg <= snap_rmin_reg;
            p_lmin_reg <= snap_lmin_reg;
        end
        if (prod_move)
        begin
            o_front_reg <= pf_reg;
            o_rear_reg  <= pb_reg;
            o_avoid_reg <= pa_reg;
            o_left_reg  <= zero_reg || (lhs_reg < rhs_reg);
            o_rmin_reg  <= p_rmin_reg;
            o_lmin_reg  <= p_lmin_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign front_obstacle  = o_front_reg;
    assign rear_obstacle   = o_rear_reg;
    assign avoid_obstacle  = o_avoid_reg;
    assign left_side_flag  = o_left_reg;
    assign right_side_flag = !o_left_reg;
    assign right_min_mm    = o_rmin_reg;
    assign left_min_mm     = o_lmin_reg;

endmodule

// File: sv/lidar_sector_obstacle_scan.sv
// Top level of the lidar sector obstacle scan: config registers, front, queue, back.
//
//  channel  handshake             payload
//  in       in_valid / in_ready   range_mm
//  out      out_valid / out_ready front/rear/avoid flags, side flags, side minima
//  cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One sample per cycle is taken while the four-entry queue has room; the back part
// drains one item per cycle unless its result stages are full, so the sustained
// rate is one item per clock while the output is taken. A scan result passes
// through queue, snapshot, cross-multiply and output registers after its last sample.
// The back part holds the last sample of a scan only while its result stages are full.
// Reset restores the register defaults and clears all running values; no clearing pass.
`timescale 1ns / 1ps
`include "lidar_sector_obstacle_scan_macros.svh"
module lidar_sector_obstacle_scan (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [lsos_pkg::RANGE_W-1:0]     range_mm,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             front_obstacle,
    output logic                             rear_obstacle,
    output logic                             avoid_obstacle,
    output logic                             left_side_flag,
    output logic                             right_side_flag,
    output logic [lsos_pkg::SIDE_W-1:0]      right_min_mm,
    output logic [lsos_pkg::SIDE_W-1:0]      left_min_mm,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lsos_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lsos_pkg::CFG_DATA_W-1:0]  cfg_data
);

    lsos_pkg::cfg_t         cfg_reg;
    lsos_pkg::cfg_t         cfg_next;
    lsos_pkg::queue_stat_t  q_stat;
    lsos_pkg::back_stat_t   b_stat;
    lsos_pkg::item_t        push_item;
    lsos_pkg::item_t        head_item;
    logic                   push;
    logic                   pop;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                lsos_pkg::CFG_SCAN_LENGTH:
                    cfg_next.scan_length = cfg_data[lsos_pkg::LEN_W-1:0];
                lsos_pkg::CFG_VALID_RANGE_MAX:
                    cfg_next.valid_range_max = cfg_data;
                lsos_pkg::CFG_FRONT_LIMIT:
                    cfg_next.front_limit = cfg_data;
                lsos_pkg::CFG_REAR_LIMIT:
                    cfg_next.rear_limit = cfg_data;
                lsos_pkg::CFG_AVOID_LIMIT:
                    cfg_next.avoid_limit = cfg_data;
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scan_length     <= lsos_pkg::SCAN_LENGTH_RST;
            cfg_reg.valid_range_max <= lsos_pkg::VALID_RANGE_MAX_RST;
            cfg_reg.front_limit     <= lsos_pkg::FRONT_LIMIT_RST;
            cfg_reg.rear_limit      <= lsos_pkg::REAR_LIMIT_RST;
            cfg_reg.avoid_limit     <= lsos_pkg::AVOID_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lsos_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .range_mm (range_mm),
        .cfg      (cfg_reg),
        .q_stat   (q_stat),
        .push     (push),
        .item     (push_item)
    );

    lsos_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item_in  (push_item),
        .pop      (pop),
        .item_out (head_item),
        .stat     (q_stat)
    );

    lsos_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_stat          (q_stat),
        .head            (head_item),
        .pop             (pop),
        .cfg             (cfg_reg),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .front_obstacle  (front_obstacle),
        .rear_obstacle   (rear_obstacle),
        .avoid_obstacle  (avoid_obstacle),
        .left_side_flag  (left_side_flag),
        .right_side_flag (right_side_flag),
        .right_min_mm    (right_min_mm),
        .left_min_mm     (left_min_mm),
        .stat            (b_stat)
    );

    `LSOS_ASSERT_IMP(a_snap_no_overwrite, clk, rst_n, b_stat.snap_load && b_stat.snap_full, b_stat.snap_move)
    `LSOS_ASSERT_NEXT(a_snap_loaded, clk, rst_n, b_stat.snap_load, b_stat.snap_full)
    `LSOS_ASSERT_IMP(a_side_flags, clk, rst_n, out_valid, left_side_flag != right_side_flag)
    `LSOS_ASSERT_IMP(a_side_min_bound, clk, rst_n, out_valid, (right_min_mm <= lsos_pkg::SIDE_MIN_INIT) && (left_min_mm <= lsos_pkg::SIDE_MIN_INIT))

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the lidar sector obstacle scan block.
`timescale 1ns / 1ps
module tb_top;

    localparam int unsigned SETTLE_CYCLES   = 16;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned RUN_LIMIT_NS    = 4_000_000;
    localparam int unsigned SCRIPT_ROWS     = 23;
    localparam int unsigned RANDOM_ITEMS    = 350;

    localparam logic [lsos_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [lsos_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic                        front_obstacle;
        logic                        rear_obstacle;
        logic                        avoid_obstacle;
        logic                        left_side_flag;
        logic                        right_side_flag;
        logic [lsos_pkg::SIDE_W-1:0] right_min_mm;
        logic [lsos_pkg::SIDE_W-1:0] left_min_mm;
    } scan_verdict_t;

    typedef enum logic {ROW_REG, ROW_RANGE} row_kind_t;

    typedef struct packed {
        row_kind_t                       kind;
        logic [lsos_pkg::CFG_IDX_W-1:0]  idx;
        logic [lsos_pkg::CFG_DATA_W-1:0] value;
        logic [lsos_pkg::LEN_W-1:0]      reps;
        logic                            typed;
        scan_verdict_t                   verdict;
    } stim_row_t;

    localparam scan_verdict_t NO_VERDICT = '0;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic [lsos_pkg::RANGE_W-1:0]    range_mm = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic                            front_obstacle;
    logic                            rear_obstacle;
    logic                            avoid_obstacle;
    logic                            left_side_flag;
    logic                            right_side_flag;
    logic [lsos_pkg::SIDE_W-1:0]     right_min_mm;
    logic [lsos_pkg::SIDE_W-1:0]     left_min_mm;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [lsos_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [lsos_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    logic [lsos_pkg::LEN_W-1:0]   set_scan_length = lsos_pkg::SCAN_LENGTH_RST;
    logic [lsos_pkg::RANGE_W-1:0] set_valid_max   = lsos_pkg::VALID_RANGE_MAX_RST;
    logic [lsos_pkg::RANGE_W-1:0] set_front_limit = lsos_pkg::FRONT_LIMIT_RST;
    logic [lsos_pkg::RANGE_W-1:0] set_rear_limit  = lsos_pkg::REAR_LIMIT_RST;
    logic [lsos_pkg::RANGE_W-1:0] set_avoid_limit = lsos_pkg::AVOID_LIMIT_RST;

    logic [lsos_pkg::IDX_W-1:0]   scan_pos;
    logic [lsos_pkg::RANGE_W-1:0] front_low;
    logic [lsos_pkg::RANGE_W-1:0] rear_low;
    logic [lsos_pkg::SIDE_W-1:0]  right_low;
    logic [lsos_pkg::SIDE_W-1:0]  left_low;
    logic [lsos_pkg::TOTAL_W-1:0] right_sum;
    logic [lsos_pkg::TOTAL_W-1:0] left_sum;
    logic [lsos_pkg::CNT_W-1:0]   right_hits;
    logic [lsos_pkg::CNT_W-1:0]   left_hits;

    scan_verdict_t due_verdicts [$];
    stim_row_t     script [0:SCRIPT_ROWS-1];
    int unsigned   faults = 0;
    int unsigned   results_seen = 0;
    bit            tx_steady = 1'b0;
    bit            hold_off_pending = 1'b0;

    lidar_sector_obstacle_scan dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .range_mm        (range_mm),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .front_obstacle  (front_obstacle),
        .rear_obstacle   (rear_obstacle),
        .avoid_obstacle  (avoid_obstacle),
        .left_side_flag  (left_side_flag),
        .right_side_flag (right_side_flag),
        .right_min_mm    (right_min_mm),
        .left_min_mm     (left_min_mm),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void restart_scan();
        scan_pos   = '0;
        front_low  = lsos_pkg::FRONT_REAR_INIT;
        rear_low   = lsos_pkg::FRONT_REAR_INIT;
        right_low  = lsos_pkg::SIDE_MIN_INIT;
        left_low   = lsos_pkg::SIDE_MIN_INIT;
        right_sum  = '0;
        left_sum   = '0;
        right_hits = '0;
        left_hits  = '0;
    endfunction

    function automatic int unsigned scan_span();
        int unsigned n;
        n = set_scan_length;
        if (n < lsos_pkg::MIN_SCAN)
            n = lsos_pkg::MIN_SCAN;
        if (n > lsos_pkg::MAX_SCAN_SAMPLES)
            n = lsos_pkg::MAX_SCAN_SAMPLES;
        return n;
    endfunction

    function automatic logic [lsos_pkg::PROD_W-1:0] left_hits_or(
        input logic [lsos_pkg::CNT_W-1:0] c);
        return lsos_pkg::PROD_W'(c);
    endfunction

    function automatic bit fold_range(input logic [lsos_pkg::RANGE_W-1:0] r,
                                      output scan_verdict_t v);
        int unsigned                 n;
        int unsigned                 i;
        int unsigned                 delta;
        int unsigned                 mid;
        bit                          hit;
        bit                          good;
        bit                          left_wins;
        logic [lsos_pkg::PROD_W-1:0] lhs;
        logic [lsos_pkg::PROD_W-1:0] rhs;
        n     = scan_span();
        i     = scan_pos;
        delta = n / 8;
        mid   = (n * 3) / 4;
        hit   = (r != lsos_pkg::NO_RETURN_MM);
        good  = hit && r != 0 && r < set_valid_max;
        v     = NO_VERDICT;
        if (i >= (3 * n) / 16 && i < (5 * n) / 16 && hit && r < front_low)
            front_low = r;
        if (i <= mid + delta && i >= mid - delta && hit && r < rear_low)
            rear_low = r;
        if (i >= (2 * n) / 16 && i < (4 * n) / 16)
        begin
            if (good)
            begin
                right_sum  = right_sum + r;
                right_hits = right_hits + 1'b1;
            end
            if (hit && r < right_low)
                right_low = r;
        end
        if (i >= (4 * n) / 16 && i < (6 * n) / 16)
        begin
            if (good)
            begin
                left_sum  = left_sum + r;
                left_hits = left_hits + 1'b1;
            end
            if (hit && r < left_low)
                left_low = r;
        end
        if (i + 1 < n)
        begin
            scan_pos = lsos_pkg::IDX_W'(i + 1);
            return 1'b0;
        end
        left_wins = 1'b1;
        if (left_hits != 0 && right_hits != 0)
        begin
            lhs       = left_sum * left_hits_or(right_hits);
            rhs       = right_sum * left_hits_or(left_hits);
            left_wins = (lhs < rhs);
        end
        v.front_obstacle  = (front_low < set_front_limit);
        v.rear_obstacle   = (rear_low < set_rear_limit);
        v.avoid_obstacle  = (front_low < set_avoid_limit);
        v.left_side_flag  = left_wins;
        v.right_side_flag = !left_wins;
        v.right_min_mm    = right_low;
        v.left_min_mm     = left_low;
        restart_scan();
        return 1'b1;
    endfunction

    function automatic logic [lsos_pkg::RANGE_W-1:0] pick_range();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return lsos_pkg::NO_RETURN_MM;
        if (roll < 13)
            return '0;
        if (roll < 55)
            return lsos_pkg::RANGE_W'($urandom_range(1, 4000));
        if (roll < 80)
            return lsos_pkg::RANGE_W'($urandom_range(4000, 20000));
        return lsos_pkg::RANGE_W'($urandom());
    endfunction

    function automatic logic [lsos_pkg::RANGE_W-1:0] pick_limit();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return '0;
        if (roll < 20)
            return '1;
        return lsos_pkg::RANGE_W'($urandom_range(0, 4000));
    endfunction

    task automatic settle();
        in_valid <= 1'b0;
        while (due_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_reg(input logic [lsos_pkg::CFG_IDX_W-1:0] idx,
                               input logic [lsos_pkg::CFG_DATA_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            lsos_pkg::CFG_SCAN_LENGTH:     set_scan_length = d[lsos_pkg::LEN_W-1:0];
            lsos_pkg::CFG_VALID_RANGE_MAX: set_valid_max   = d;
            lsos_pkg::CFG_FRONT_LIMIT:     set_front_limit = d;
            lsos_pkg::CFG_REAR_LIMIT:      set_rear_limit  = d;
            lsos_pkg::CFG_AVOID_LIMIT:     set_avoid_limit = d;
            default: ;
        endcase
    endtask

    task automatic push_range(input logic [lsos_pkg::RANGE_W-1:0] r, input bit use_given,
                              input scan_verdict_t given);
        scan_verdict_t v;
        if (!tx_steady && $urandom_range(0, 99) < 10)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        range_mm <= r;
        do
            @(posedge clk);
        while (!in_ready);
        if (fold_range(r, v))
            due_verdicts.insert(due_verdicts.size(), use_given ? given : v);
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            faults++;
        end
    endtask

    always @(posedge clk)
    begin
        scan_verdict_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (due_verdicts.size() == 0)
            begin
                $error("result item with no scan pending");
                faults++;
            end
            else
            begin
                want = due_verdicts.pop_front();
                results_seen++;
                check_field("front_obstacle", want.front_obstacle, front_obstacle);
                check_field("rear_obstacle", want.rear_obstacle, rear_obstacle);
                check_field("avoid_obstacle", want.avoid_obstacle, avoid_obstacle);
                check_field("left_side_flag", want.left_side_flag, left_side_flag);
                check_field("right_side_flag", want.right_side_flag, right_side_flag);
                check_field("right_min_mm", want.right_min_mm, right_min_mm);
                check_field("left_min_mm", want.left_min_mm, left_min_mm);
            end
        end
    end

    initial
    begin
        int unsigned rx_cycles;
        rx_cycles = 0;
        forever
        begin
            @(posedge clk);
            rx_cycles++;
            if (hold_off_pending)
            begin
                hold_off_pending = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                rx_cycles += HOLD_OFF_CYCLES;
            end
            else
            begin
                out_ready <= (rx_cycles >= 1500 && rx_cycles < 3000)
                             || ($urandom_range(0, 99) >= 10);
            end
        end
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int unsigned                     k;
        int unsigned                     j;
        int unsigned                     phase_no;
        int unsigned                     items;
        int unsigned                     span;
        int unsigned                     roll;
        int unsigned                     random_items;
        logic [lsos_pkg::LEN_W-1:0]      len;
        logic [lsos_pkg::RANGE_W-1:0]    vmax;
        logic [lsos_pkg::CFG_DATA_W-1:0] len_word;

        script = '{
            '{ROW_REG,   lsos_pkg::CFG_SCAN_LENGTH,     16'hF800, 11'd1,  1'b0, NO_VERDICT},
            '{ROW_RANGE, lsos_pkg::CFG_SCAN_LENGTH,     lsos_pkg::NO_RETURN_MM, 11'd16, 1'b1,
              '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, lsos_pkg::SIDE_MIN_INIT, lsos_pkg::SIDE_MIN_INIT}},
            '{ROW_RANGE, lsos_pkg::CFG_SCAN_LENGTH,     16'd1,    11'd4,  1'b0, NO_VERDICT},
            '{ROW_RANGE, lsos_pkg::CFG_SCAN_LENGTH,     16'd11999, 11'd2, 1'b0, NO_VERDICT},
            '{ROW_RANGE, lsos_pkg::CFG_SCAN_LENGTH,     16'hAAAA, 11'd6,  1'b0, NO_VERDICT},
            '{ROW_RANGE, lsos_pkg::CFG_SCAN_LENGTH,     16'h5555, 11'd4,  1'b0, NO_VERDICT},
            '{ROW_REG,   lsos_pkg::CFG_VALID_RANGE_MAX, 16'h0000, 11'd1,  1'b0, NO_VERDICT},
            '{ROW_REG,   lsos_pkg::CFG_FRONT_LIMIT,     16'hFFFF, 11'd1,  1'b0, NO_VERDICT},
            '{ROW_REG,   lsos_pkg::CFG_REAR_LIMIT,      16'hFFFF, 11'd1,  1'b0, NO_VERDICT},
            '{ROW_REG,   lsos_pkg::CFG_AVOID_LIMIT,     16'h0000, 11'd1,  1'b0, NO_VERDICT},
            '{ROW_REG,   CFG_SPARE_LO,                  16'hFFFF, 11'd1,  1'b0, NO_VERDICT},
            '{ROW_REG,   CFG_SPARE_HI,                  16'h0000, 11'd1,  1'b0, NO_VERDICT},
            '{ROW_RANGE, lsos_pkg::CFG_SCAN_LENGTH,     16'd100,  11'd16, 1'b1,
              '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 17'd100, 17'd100}},
            '{ROW_REG,   lsos_pkg::CFG_SCAN_LENGTH,     16'd20,   11'd1,  1'b0, NO_VERDICT},
            '{ROW_RANGE, lsos_pkg::CFG_SCAN_LENGTH,     16'h1234, 11'd18, 1'b0, NO_VERDICT},
            '{ROW_REG,   lsos_pkg::CFG_SCAN_LENGTH,     16'd16,   11'd1,  1'b0, NO_VERDICT},
            '{ROW_RANGE, lsos_pkg::CFG_SCAN_LENGTH,     16'hEDCB, 11'd1,  1'b0, NO_VERDICT},
            '{ROW_REG,   lsos_pkg::CFG_VALID_RANGE_MAX, 16'hFFFF, 11'd1,  1'b0, NO_VERDICT},
            '{ROW_REG,   lsos_pkg::CFG_FRONT_LIMIT,     16'h0000, 11'd1,  1'b0, NO_VERDICT},
            '{ROW_REG,   lsos_pkg::CFG_REAR_LIMIT,      16'h0000, 11'd1,  1'b0, NO_VERDICT},
            '{ROW_REG,   lsos_pkg::CFG_AVOID_LIMIT,     16'hFFFF, 11'd1,  1'b0, NO_VERDICT},
            '{ROW_RANGE, lsos_pkg::CFG_SCAN_LENGTH,     16'd0,    11'd16, 1'b1,
              '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 17'd0, 17'd0}},
            '{ROW_RANGE, lsos_pkg::CFG_SCAN_LENGTH,     16'd65534, 11'd16, 1'b1,
              '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 17'd65534, 17'd65534}}
        };

        restart_scan();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < SCRIPT_ROWS; k++)
        begin
            if (script[k].kind == ROW_REG)
            begin
                if (k == 0 || script[k-1].kind != ROW_REG)
                    settle();
                program_reg(script[k].idx, script[k].value);
                if (k + 1 == SCRIPT_ROWS || script[k+1].kind != ROW_REG)
                    cfg_valid <= 1'b0;
            end
            else
            begin
                for (j = 0; j < script[k].reps; j++)
                    push_range(script[k].value, script[k].typed && j + 1 == script[k].reps,
                               script[k].verdict);
            end
        end

        random_items = 0;
        phase_no = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            phase_no++;
            settle();
            if (phase_no == 2)
            begin
                len = 11'd16;
                hold_off_pending = 1'b1;
            end
            else if (phase_no == 5)
                len = lsos_pkg::LEN_W'($urandom_range(1024, 2047));
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 60)
                    len = lsos_pkg::LEN_W'($urandom_range(16, 24));
                else if (roll < 80)
                    len = lsos_pkg::LEN_W'($urandom_range(0, 15));
                else
                    len = lsos_pkg::LEN_W'($urandom_range(25, 80));
            end
            roll = $urandom_range(0, 99);
            if (roll < 12)
                vmax = '0;
            else if (roll < 22)
                vmax = '1;
            else if (roll < 30)
                vmax = lsos_pkg::RANGE_W'(1);
            else
                vmax = lsos_pkg::RANGE_W'($urandom_range(1, 16000));
            len_word = lsos_pkg::CFG_DATA_W'(len)
                       | (lsos_pkg::CFG_DATA_W'($urandom_range(0, 31)) << lsos_pkg::LEN_W);
            program_reg(lsos_pkg::CFG_SCAN_LENGTH, len_word);
            program_reg(lsos_pkg::CFG_VALID_RANGE_MAX, vmax);
            program_reg(lsos_pkg::CFG_FRONT_LIMIT, pick_limit());
            program_reg(lsos_pkg::CFG_REAR_LIMIT, pick_limit());
            program_reg(lsos_pkg::CFG_AVOID_LIMIT, pick_limit());
            if ($urandom_range(0, 3) == 0)
                program_reg(lsos_pkg::CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
                            lsos_pkg::CFG_DATA_W'($urandom()));
            cfg_valid <= 1'b0;

            span = scan_span();
            if (phase_no == 2)
                items = span * 6;
            else if (phase_no == 5)
                items = $urandom_range(8, 40);
            else
                items = span * $urandom_range(1, 4) + $urandom_range(0, span - 1);
            repeat (items)
            begin
                tx_steady = (random_items >= 120 && random_items < 280);
                push_range(pick_range(), 1'b0, NO_VERDICT);
                random_items++;
            end
        end

        tx_steady = 1'b0;
        settle();
        if (faults == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
